@@ hw/rtl/spike_record_frame_packer_unit_macros.svh @@
// Assertion macros shared by the spike record frame packer RTL.
`ifndef SPIKE_RECORD_FRAME_PACKER_UNIT_MACROS_SVH
`define SPIKE_RECORD_FRAME_PACKER_UNIT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked at every rising edge outside reset.
`define SRFP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srfp assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define SRFP_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srfp assertion failed");
`else
`define SRFP_ASSERT_IMP(label, clk, rst, ante, cons)
`define SRFP_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

@@ hw/rtl/srfp_pkg.sv @@
// Shared types and constants of the spike record frame packer.
package srfp_pkg;

  // Default build parameters.
  localparam int FRAME_BYTES_DEF = 4096;
  localparam int FRAC_BITS_DEF   = 8;

  // Fixed field widths.
  localparam int ADDR_W    = 12;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;
  localparam int PAYLOAD_W = 40;
  localparam int NB_W      = 3;

  // Job queue between the front and the serializer.
  localparam int QUEUE_DEPTH = 2;

  // Command codes.
  localparam logic [1:0] CMD_SPIKE_FULL  = 2'd0;
  localparam logic [1:0] CMD_SPIKE_LOCAL = 2'd1;
  localparam logic [1:0] CMD_FLUSH       = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DROP = 2'd1;
  localparam logic [1:0] ST_CLIP = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GID_BYTES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_TIME = 2'd2;

  // One emit job: a run of consecutive frame bytes, first byte in the top bits.
  typedef struct packed {
    logic [ADDR_W-1:0]    base;
    logic [NB_W-1:0]      nbytes;
    logic [PAYLOAD_W-1:0] payload;
    logic [1:0]           status;
  } job_t;

  // Queue status seen by the front and the serializer.
  typedef struct packed {
    logic valid;
    logic full;
  } qstat_t;

endpackage

@@ hw/rtl/srfp_front.sv @@
// Front end: takes input beats, keeps frame state and builds emit jobs.
module srfp_front #(
  parameter int FRAME_BYTES = srfp_pkg::FRAME_BYTES_DEF,
  parameter int FRAC_BITS   = srfp_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [srfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [srfp_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     command,
  input  logic [31:0]                    gid,
  input  logic [31:0]                    fire_time,
  input  logic [31:0]                    current_time,
  input  srfp_pkg::qstat_t               qstat,
  output logic                           push,
  output srfp_pkg::job_t                 push_job
);
  import srfp_pkg::*;

  localparam int OFFS_W = $clog2(FRAME_BYTES + 1);
  localparam logic [33:0] HALF = 34'((64'(1) << FRAC_BITS) >> 1);
  localparam logic [OFFS_W:0] FRAME_LIMIT = (OFFS_W + 1)'(FRAME_BYTES);
  localparam logic [OFFS_W-1:0] OFFS_START = OFFS_W'(2);

  // Configuration and frame state.
  logic              enabled;
  logic [NB_W-1:0]   gid_bytes;
  logic [31:0]       exchange_time;
  logic [OFFS_W-1:0] write_offset;
  logic [15:0]       spike_count;

  logic              accept;
  logic [NB_W-1:0]   nb;
  logic [NB_W-1:0]   reclen;
  logic [OFFS_W:0]   end_offset;
  logic              drop;
  logic [33:0]       diff;
  logic [32:0]       steps;
  logic [7:0]        tbyte;
  logic [1:0]        tstatus;
  logic [31:0]       gid_al;
  logic              is_spike;

  assign in_ready = !qstat.full;
  assign accept   = in_valid && in_ready;

  // Gid byte count: one in local mode, else the register clamped to 1..4.
  always_comb begin
    if (command == CMD_SPIKE_LOCAL) begin
      nb = NB_W'(1);
    end else if (gid_bytes == NB_W'(0)) begin
      nb = NB_W'(1);
    end else if (gid_bytes > NB_W'(4)) begin
      nb = NB_W'(4);
    end else begin
      nb = gid_bytes;
    end
  end

  assign reclen     = nb + NB_W'(1);
  assign end_offset = {1'b0, write_offset} + (OFFS_W + 1)'(reclen);
  assign drop       = (spike_count == 16'hFFFF) || (end_offset > FRAME_LIMIT);

  // Time byte: offset to the exchange time rounded half up, then clipped.
  assign diff  = {2'b00, fire_time} - {2'b00, exchange_time} + HALF;
  assign steps = diff[32:0] >> FRAC_BITS;
  always_comb begin
    if (diff[33]) begin
      tbyte   = 8'd0;
      tstatus = ST_CLIP;
    end else if (steps[32:8] != 25'd0) begin
      tbyte   = 8'hFF;
      tstatus = ST_CLIP;
    end else begin
      tbyte   = steps[7:0];
      tstatus = ST_OK;
    end
  end

  // Gid bytes moved to the top so the serializer sends them right after the time byte.
  always_comb begin
    case (nb)
      NB_W'(1): gid_al = {gid[7:0], 24'd0};
      NB_W'(2): gid_al = {gid[15:0], 16'd0};
      NB_W'(3): gid_al = {gid[23:0], 8'd0};
      default:  gid_al = gid;
    endcase
  end

  // Classify the beat and build its job.
  always_comb begin
    push     = 1'b0;
    is_spike = 1'b0;
    push_job = '0;
    case (command)
      CMD_FLUSH: begin
        push             = accept && enabled;
        push_job.base    = '0;
        push_job.nbytes  = NB_W'(2);
        push_job.payload = {spike_count, 24'd0};
        push_job.status  = ST_OK;
      end
      CMD_SPIKE_FULL, CMD_SPIKE_LOCAL: begin
        push = accept && enabled;
        if (drop) begin
          push_job.base    = '0;
          push_job.nbytes  = NB_W'(1);
          push_job.payload = '0;
          push_job.status  = ST_DROP;
        end else begin
          is_spike         = 1'b1;
          push_job.base    = ADDR_W'(write_offset);
          push_job.nbytes  = reclen;
          push_job.payload = {tbyte, gid_al};
          push_job.status  = tstatus;
        end
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  // Configuration writes and frame state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled       <= 1'b0;
      gid_bytes     <= NB_W'(4);
      exchange_time <= '0;
      write_offset  <= OFFS_START;
      spike_count   <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_ENABLED:    enabled <= cfg_data[0];
          CFG_GID_BYTES:  gid_bytes <= cfg_data[NB_W-1:0];
          CFG_START_TIME: exchange_time <= cfg_data;
          default:        enabled <= enabled;
        endcase
      end
      if (push && command == CMD_FLUSH) begin
        spike_count   <= '0;
        write_offset  <= OFFS_START;
        exchange_time <= current_time;
      end else if (push && is_spike) begin
        spike_count  <= spike_count + 16'd1;
        write_offset <= end_offset[OFFS_W-1:0];
      end
    end
  end

endmodule

@@ hw/rtl/srfp_queue.sv @@
// Short job queue that decouples the front end from the serializer.
module srfp_queue (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       push,
  input  srfp_pkg::job_t                             push_job,
  input  logic                                       pop,
  output srfp_pkg::job_t                             pop_job,
  output srfp_pkg::qstat_t                           qstat,
  output logic [$clog2(srfp_pkg::QUEUE_DEPTH+1)-1:0] count
);
  import srfp_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  assign qstat.valid = (count != CNT_W'(0));
  assign qstat.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign pop_job     = slots[rd_ptr];

  // Pointer and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

@@ hw/rtl/srfp_back.sv @@
// Serializer: sends each queued job as one frame byte per output beat.
module srfp_back (
  input  logic                        clk,
  input  logic                        rst,
  input  srfp_pkg::qstat_t            qstat,
  input  srfp_pkg::job_t              pop_job,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [srfp_pkg::ADDR_W-1:0] frame_addr,
  output logic [7:0]                  data_byte,
  output logic                        last,
  output logic [1:0]                  status
);
  import srfp_pkg::*;

  // Job being sent.
  logic                 active;
  logic [ADDR_W-1:0]    cur_addr;
  logic [NB_W-1:0]      remain;
  logic [PAYLOAD_W-1:0] payload;
  logic [1:0]           cur_status;

  logic emit;
  logic finishing;

  assign emit      = active && (!out_valid || out_ready);
  assign finishing = emit && (remain == NB_W'(1));
  assign pop       = qstat.valid && (!active || finishing);

  // Control: job activity and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        active <= 1'b1;
      end else if (finishing) begin
        active <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath: load a job, or step through its bytes.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_addr   <= pop_job.base;
      remain     <= pop_job.nbytes;
      payload    <= pop_job.payload;
      cur_status <= pop_job.status;
    end else if (emit) begin
      cur_addr <= cur_addr + ADDR_W'(1);
      remain   <= remain - NB_W'(1);
      payload  <= {payload[PAYLOAD_W-9:0], 8'd0};
    end
    if (emit) begin
      frame_addr <= cur_addr;
      data_byte  <= payload[PAYLOAD_W-1 -: 8];
      last       <= (remain == NB_W'(1));
      status     <= cur_status;
    end
  end

endmodule

@@ hw/rtl/spike_record_frame_packer_unit.sv @@
// Top level of the spike record frame packer.
//
// Input channel (in_valid/in_ready) takes one command beat: a spike with a
// full gid, a spike with a local gid, or a frame flush. Output channel
// (out_valid/out_ready) gives one frame byte per beat with its address, a
// last flag on the final byte of the command and a status code.
// A spike gives its time byte and 1 to 4 gid bytes (2 to 5 beats); a dropped
// spike gives one status beat; a flush gives the two count bytes.
// The serializer sends one byte per cycle while the receiver is ready, and
// loads the next job as it sends the last byte of the one before.
// When the block is idle, the first byte of a command passes through the job
// queue and the serializer's job registers to the output register. Commands
// while disabled, and unknown commands, are taken and give nothing.
// The configuration port writes a register whenever cfg_write is high and
// cfg_index names one; a start time write also loads the exchange time.
// Reset clears the queue and output, sets the offset to 2, the count to 0,
// the gid width to 4 and disables the block. When the receiver stalls, the
// output register holds, the serializer waits, and the two-entry job queue
// fills before in_ready drops.
`include "spike_record_frame_packer_unit_macros.svh"
module spike_record_frame_packer_unit #(
  parameter int FRAME_BYTES = srfp_pkg::FRAME_BYTES_DEF,
  parameter int FRAC_BITS   = srfp_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [srfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [srfp_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     command,
  input  logic [31:0]                    gid,
  input  logic [31:0]                    fire_time,
  input  logic [31:0]                    current_time,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [srfp_pkg::ADDR_W-1:0]    frame_addr,
  output logic [7:0]                     data_byte,
  output logic                           last,
  output logic [1:0]                     status
);
  import srfp_pkg::*;

  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  qstat_t            qstat;
  logic              q_push;
  logic              q_pop;
  job_t              push_job;
  job_t              pop_job;
  logic [QCNT_W-1:0] q_count;

  // Front end: command decode and frame state.
  srfp_front #(
    .FRAME_BYTES(FRAME_BYTES),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .gid         (gid),
    .fire_time   (fire_time),
    .current_time(current_time),
    .qstat       (qstat),
    .push        (q_push),
    .push_job    (push_job)
  );

  // Job queue.
  srfp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_job(push_job),
    .pop     (q_pop),
    .pop_job (pop_job),
    .qstat   (qstat),
    .count   (q_count)
  );

  // Byte serializer with output register.
  srfp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .qstat     (qstat),
    .pop_job   (pop_job),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .frame_addr(frame_addr),
    .data_byte (data_byte),
    .last      (last),
    .status    (status)
  );

  // Queue discipline between front and serializer.
  `SRFP_ASSERT_IMP(a_no_push_full, clk, rst, q_push, !qstat.full)
  `SRFP_ASSERT_IMP(a_no_pop_empty, clk, rst, q_pop, qstat.valid)
  `SRFP_ASSERT_NXT(a_push_lands, clk, rst, q_push, qstat.valid)
  `SRFP_ASSERT_IMP(a_count_range, clk, rst, 1'b1, q_count <= QCNT_W'(QUEUE_DEPTH))

endmodule
